>>> rtl/core/rhs_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rhs_pkg;

  localparam int ChanW   = 8;
  localparam int HueW    = 16;
  localparam int SatW    = 16;

  localparam int DivDenW = ChanW + 1;
  localparam int DivQuoW = 16;
  localparam int DivNumW = DivDenW + DivQuoW;
  localparam int DivLat  = DivQuoW + 1;

  localparam int SatFracW = 15;

  localparam logic [HueW-1:0] FullTurn = 16'd46080;
  localparam logic [15:0]     Deg60    = 16'd7680;
  localparam logic [15:0]     Deg120   = 16'd15360;
  localparam logic [15:0]     Deg240   = 16'd30720;
  localparam logic [15:0]     Deg360   = 16'd46080;

  typedef enum logic [1:0] {
    SectorRed,
    SectorGreen,
    SectorBlue
  } hue_sector_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
  } out_word_t;

  typedef struct packed {
    logic             grey;
    logic             black;
    logic [ChanW-1:0] brightness;
  } side_t;

endpackage

>>> rtl/core/rhs_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module rhs_divider
  import rhs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [DivNumW-1:0] num,
  input  logic [DivDenW-1:0] den,
  output logic [DivQuoW-1:0] quo
);

  logic [DivDenW-1:0] rem_r [0:DivQuoW];
  logic [DivQuoW-1:0] low_r [0:DivQuoW];
  logic [DivDenW-1:0] den_r [0:DivQuoW];
  logic [DivQuoW-1:0] quo_r [0:DivQuoW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[DivNumW-1:DivQuoW];
      low_r[0] <= num[DivQuoW-1:0];
      den_r[0] <= den;
      quo_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < DivQuoW; k++) begin : g_step
    logic [DivDenW:0]   trial;
    logic [DivDenW+1:0] diff;
    logic               borrow;

    assign trial  = {rem_r[k], low_r[k][DivQuoW-1]};
    assign diff   = {1'b0, trial} - {2'b00, den_r[k]};
    assign borrow = diff[DivDenW+1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= borrow ? trial[DivDenW-1:0] : diff[DivDenW-1:0];
        low_r[k+1] <= {low_r[k][DivQuoW-2:0], 1'b0};
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= {quo_r[k][DivQuoW-2:0], ~borrow};
      end
    end
  end

  assign quo = quo_r[DivQuoW];

endmodule

>>> rtl/core/rgb_to_hsv_converter.sv
// Top level: RGB to HSV pixel converter pipeline.
// Stages from input accept to output valid: range stage, 17-stage
//   bit-per-cycle divider pair, output stage.
// Throughput: one word per cycle; the whole pipe holds while out_stall
//   blocks a waiting result, bubbles included.
// Reset: rst_n clears all valid bits synchronously; no other state.
module rgb_to_hsv_converter
  import rhs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic en;

  // stage 1: range and sector
  logic [ChanW-1:0]  top, bottom;
  hue_sector_t       sector;
  logic signed [ChanW:0] delta;

  logic              s1_vld_r;
  logic [ChanW-1:0]  s1_top_r;
  logic [ChanW-1:0]  s1_spread_r;
  hue_sector_t       s1_sector_r;
  logic signed [ChanW:0] s1_delta_r;

  // stage 2 inputs to dividers
  logic [15:0]        offset;
  logic [25:0]        term_delta;
  logic [25:0]        term_off;
  logic [25:0]        numer;
  logic [DivNumW-1:0] hue_num;
  logic [DivDenW-1:0] hue_den;
  logic [DivNumW-1:0] sat_num;
  logic [DivDenW-1:0] sat_den;
  logic [DivQuoW-1:0] hue_quo;
  logic [DivQuoW-1:0] sat_quo;

  logic [DivLat-1:0]  vld_r;
  side_t              side_r [0:DivLat-1];

  logic [HueW-1:0]    hue_wrap;
  logic               out_valid_r;
  out_word_t          out_word_r;

  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  always_comb begin
    top    = in_word.red;
    bottom = in_word.red;
    if (in_word.green > top)    top    = in_word.green;
    if (in_word.blue > top)     top    = in_word.blue;
    if (in_word.green < bottom) bottom = in_word.green;
    if (in_word.blue < bottom)  bottom = in_word.blue;
    if (in_word.blue == top) begin
      sector = SectorBlue;
      delta  = $signed({1'b0, in_word.red}) - $signed({1'b0, in_word.green});
    end else if (in_word.green == top) begin
      sector = SectorGreen;
      delta  = $signed({1'b0, in_word.blue}) - $signed({1'b0, in_word.red});
    end else begin
      sector = SectorRed;
      delta  = $signed({1'b0, in_word.green}) - $signed({1'b0, in_word.blue});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_top_r    <= top;
      s1_spread_r <= top - bottom;
      s1_sector_r <= sector;
      s1_delta_r  <= delta;
    end
  end

  always_comb begin
    case (s1_sector_r)
      SectorBlue:  offset = Deg240;
      SectorGreen: offset = Deg120;
      SectorRed:   offset = Deg360;
      default:     offset = Deg360;
    endcase
    term_delta = {{10{1'b0}}, Deg60} * {{(26-ChanW-1){s1_delta_r[ChanW]}}, s1_delta_r};
    term_off   = {{10{1'b0}}, offset} * {{(26-ChanW){1'b0}}, s1_spread_r};
    numer      = term_delta + term_off;
    hue_num    = {numer[DivNumW-2:0], 1'b0} + {{(DivNumW-ChanW){1'b0}}, s1_spread_r};
    hue_den    = {s1_spread_r, 1'b0};
    sat_num    = {{(DivNumW-ChanW-SatFracW){1'b0}}, s1_spread_r, {SatFracW{1'b0}}};
    sat_den    = {1'b0, s1_top_r};
  end

  rhs_divider u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  rhs_divider u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DivLat-2:0], s1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].grey       <= (s1_spread_r == '0);
      side_r[0].black      <= (s1_top_r == '0);
      side_r[0].brightness <= s1_top_r;
    end
  end

  for (genvar k = 1; k < DivLat; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign hue_wrap = (hue_quo >= FullTurn) ? (hue_quo - FullTurn) : hue_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DivLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.hue        <= side_r[DivLat-1].grey  ? '0 : hue_wrap;
      out_word_r.saturation <= side_r[DivLat-1].black ? '0 : sat_quo;
      out_word_r.brightness <= side_r[DivLat-1].brightness;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/core/rhs_checker.sv
// Port-level assertions for the RGB to HSV converter, bound to the top level.
module rhs_checker
  import rhs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.hue < FullTurn)
    else $error("hue not wrapped below a full turn");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.saturation <= (SatW'(1) << SatFracW))
    else $error("saturation above 1.0");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.brightness == '0 |->
      out_word.saturation == '0 && out_word.hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind rgb_to_hsv_converter rhs_checker u_rhs_checker (.*);

>>> bench/tb_rgb_to_hsv_converter.sv
// Self-checking testbench for rgb_to_hsv_converter: directed pixels, then random stream.
module tb_rgb_to_hsv_converter;
  import rhs_pkg::*;

  typedef struct {
    in_word_t  px;
    bit        typed;
    out_word_t want;
  } pixel_case_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  bit        word_typed = 1'b0;
  out_word_t word_want = '0;

  out_word_t hsv_q[$];
  int        accept_count = 0;
  int        error_count = 0;

  rgb_to_hsv_converter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #4 clk = ~clk;

  function automatic out_word_t hsv_of(in_word_t px);
    int r, g, b, top, bottom, spread, delta, base, numer, h, sat;
    hue_sector_t sector;
    out_word_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    // ties: blue beats green, green beats red
    if (b == top) sector = SectorBlue;
    else if (g == top) sector = SectorGreen;
    else sector = SectorRed;
    case (sector)
      SectorBlue: begin
        delta = r - g;
        base = int'(Deg240);
      end
      SectorGreen: begin
        delta = b - r;
        base = int'(Deg120);
      end
      default: begin
        delta = g - b;
        base = int'(Deg360);
      end
    endcase
    h = 0;
    if (spread != 0) begin
      numer = int'(Deg60) * delta + base * spread;
      h = (2 * numer + spread) / (2 * spread);
      if (h >= int'(FullTurn)) h = h - int'(FullTurn);
    end
    sat = (top != 0) ? (spread << SatFracW) / top : 0;
    res.hue = h[HueW-1:0];
    res.saturation = sat[SatW-1:0];
    res.brightness = top[ChanW-1:0];
    return res;
  endfunction

  function automatic pixel_case_t mk(int r, int g, int b, bit typed, int h, int s, int v);
    pixel_case_t c;
    c.px = '{red: r[7:0], green: g[7:0], blue: b[7:0]};
    c.typed = typed;
    c.want = '{hue: h[15:0], saturation: s[15:0], brightness: v[7:0]};
    return c;
  endfunction

  function automatic in_word_t rand_pixel();
    in_word_t px;
    int top, mode;
    mode = $urandom_range(9);
    px.red = 8'($urandom);
    px.green = 8'($urandom);
    px.blue = 8'($urandom);
    top = $urandom_range(255);
    case (mode)
      0, 1, 2, 3: ;
      4, 5: begin
        // narrow spread: every channel at or just under one common level
        px.red = 8'(top - $urandom_range(3) * (top >= 3));
        px.green = 8'(top - $urandom_range(3) * (top >= 3));
        px.blue = 8'(top - $urandom_range(3) * (top >= 3));
      end
      6: begin
        case ($urandom_range(2))
          0: px.green = px.red;
          1: px.blue = px.green;
          default: px.blue = px.red;
        endcase
      end
      7: begin
        px.red = 8'(top);
        px.green = 8'(top);
        px.blue = 8'(top);
      end
      default: begin
        px.red = $urandom_range(1) ? 8'hff : 8'h00;
        px.green = $urandom_range(1) ? 8'hff : 8'($urandom_range(1));
        px.blue = $urandom_range(1) ? 8'hfe : 8'h00;
      end
    endcase
    return px;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_pixel(input in_word_t px, input bit typed, input out_word_t want);
    bit quiet;
    @(negedge clk);
    quiet = accept_count >= 300 && accept_count < 500;
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = px;
    word_typed = typed;
    word_want = want;
    do @(posedge clk); while (in_stall);
  endtask

  // accepted words become expectations
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      hsv_q.push_back(word_typed ? word_want : hsv_of(in_word));
      accept_count <= accept_count + 1;
    end
  end

  always @(negedge clk) begin
    if (accept_count >= 300 && accept_count < 500) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hsv_q.size() == 0) begin
        flag_error($sformatf("unexpected word %h", out_word));
      end else begin
        want = hsv_q.pop_front();
        if (out_word.hue !== want.hue)
          flag_error($sformatf("hue %0d, want %0d", out_word.hue, want.hue));
        if (out_word.saturation !== want.saturation)
          flag_error($sformatf("saturation %0d, want %0d",
                               out_word.saturation, want.saturation));
        if (out_word.brightness !== want.brightness)
          flag_error($sformatf("brightness %0d, want %0d",
                               out_word.brightness, want.brightness));
      end
    end
  end

  initial begin
    pixel_case_t directed[$];
    directed.push_back(mk(0, 0, 0, 1, 0, 0, 0));             // black
    directed.push_back(mk(255, 255, 255, 1, 0, 0, 255));     // white
    directed.push_back(mk(128, 128, 128, 1, 0, 0, 128));     // grey
    directed.push_back(mk(255, 0, 0, 1, 0, 32768, 255));     // full turn wraps to 0
    directed.push_back(mk(0, 255, 0, 1, 15360, 32768, 255));
    directed.push_back(mk(0, 0, 255, 1, 30720, 32768, 255));
    directed.push_back(mk(255, 255, 0, 1, 7680, 32768, 255));  // tie r/g
    directed.push_back(mk(0, 255, 255, 1, 23040, 32768, 255)); // tie g/b
    directed.push_back(mk(255, 0, 255, 1, 38400, 32768, 255)); // tie r/b
    directed.push_back(mk(1, 0, 0, 1, 0, 32768, 1));
    directed.push_back(mk(255, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(200, 10, 10, 0, 0, 0, 0));
    directed.push_back(mk(255, 254, 253, 0, 0, 0, 0));
    directed.push_back(mk(1, 2, 3, 0, 0, 0, 0));
    directed.push_back(mk(170, 85, 170, 0, 0, 0, 0));
    directed.push_back(mk(85, 170, 0, 0, 0, 0, 0));
    directed.push_back(mk(254, 255, 1, 0, 0, 0, 0));
    directed.push_back(mk(0, 1, 255, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_pixel(directed[i].px, directed[i].typed, directed[i].want);

    for (int n = 0; n < 1050; n++) begin
      if (n == 700) begin
        // hold off until the pipe has drained
        @(negedge clk);
        in_valid = 1'b0;
        while (hsv_q.size() != 0) @(posedge clk);
      end
      send_pixel(rand_pixel(), 1'b0, '0);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (hsv_q.size() != 0) @(posedge clk);
    repeat (4 * DivLat) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_rgb_to_hsv_converter passed");
    end else begin
      $display("tb_rgb_to_hsv_converter failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_rgb_to_hsv_converter failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rhs_pkg.sv
rtl/core/rhs_divider.sv
rtl/core/rgb_to_hsv_converter.sv
rtl/core/rhs_checker.sv
bench/tb_rgb_to_hsv_converter.sv
